// ----- hdl/npc_pkg.sv -----
// Shared constants and types of the nearest palette color search.
package npc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int SQ_W = 16;
    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 256 * 3);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_dist_ctl;

endpackage

// ----- hdl/npc_ifs.sv -----
// Valid/ready channel interfaces for query items and result items.
interface npc_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, mode, entry_index, red, green, blue, input ready);
    modport sink (input valid, mode, entry_index, red, green, blue, output ready);
endinterface

interface npc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] best_index;

    modport source (output valid, best_index, input ready);
    modport sink (input valid, best_index, output ready);
endinterface

// ----- hdl/npc_cell.sv -----
// One palette cell of the rotating ring: holds one entry, loads or takes its neighbor's.
module npc_cell
    import npc_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_color    i_load_data,
    input  t_color    i_next,
    output t_color    o_data
);

    t_color r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_load_data;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

// ----- hdl/npc_dist.sv -----
// Distance unit at the ring head: squares, then sum and running minimum.
module npc_dist
    import npc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dist_ctl        i_ctl,
    input  t_color           i_query,
    input  t_color           i_entry,
    input  logic [IDX_W-1:0] i_idx,
    output logic [IDX_W-1:0] o_best_idx,
    output logic             o_busy
);

    function automatic logic [SQ_W-1:0] square_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return {8'd0, d} * {8'd0, d};
    endfunction

    logic [SQ_W-1:0]   r_sq_red;
    logic [SQ_W-1:0]   r_sq_green;
    logic [SQ_W-1:0]   r_sq_blue;
    logic [IDX_W-1:0]  r_idx;
    logic              r_valid;
    logic [DIST_W-1:0] r_best_dist;
    logic [IDX_W-1:0]  r_best_idx;
    logic [DIST_W-1:0] w_sum;

    assign w_sum = DIST_W'(r_sq_red) + DIST_W'(r_sq_green) + DIST_W'(r_sq_blue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_red   <= square_diff(i_entry.red, i_query.red);
        r_sq_green <= square_diff(i_entry.green, i_query.green);
        r_sq_blue  <= square_diff(i_entry.blue, i_query.blue);
        r_idx      <= i_idx;
    end

    // strict less-than keeps the lowest index on a tie
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_best_dist <= DIST_START;
            r_best_idx  <= '0;
        end else if (r_valid && (w_sum < r_best_dist)) begin
            r_best_dist <= w_sum;
            r_best_idx  <= r_idx;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_busy     = r_valid;

endmodule

// ----- hdl/nearest_palette_color.sv -----
// Top level: palette ring of cells, distance unit, query memory and output register.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------------
//  i_item    | in  | valid / ready | mode, entry_index, red, green, blue
//  o_result  | out | valid / ready | best_index
//
// A palette write gives no result; a repeated query is answered from the query
// memory in the cycle after it is accepted.
// Any other query rotates the PALETTE_ENTRIES-cell ring once past the single
// distance unit, through ST_SCAN and ST_DRAIN, before its result is registered.
// Reset (synchronous, active low) clears control and the query memory; the palette
// is undefined until written. A stalled result is held in the output register.
module nearest_palette_color
    import npc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    npc_in_if.sink    i_item,
    npc_out_if.source o_result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;
    t_color           r_query;
    t_color           r_last_color;
    logic             r_last_valid;
    logic [IDX_W-1:0] r_last_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_idx;

    t_color           w_color;
    logic             w_acc;
    logic             w_write_ok;
    logic             w_query;
    logic             w_hit;
    logic             w_out_free;
    logic             w_finish;
    logic             w_busy;
    logic [IDX_W-1:0] w_best;
    t_dist_ctl        w_dist_ctl;
    t_color           w_cell [PALETTE_ENTRIES];

    assign w_color    = t_color'({i_item.red, i_item.green, i_item.blue});
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_acc      = i_item.valid && i_item.ready;
    assign w_write_ok = w_acc && (i_item.mode == MODE_WRITE)
                        && ({1'b0, i_item.entry_index} < 9'(PALETTE_ENTRIES));
    assign w_query    = w_acc && (i_item.mode == MODE_QUERY);
    assign w_hit      = r_last_valid && (r_last_color == w_color);
    assign w_finish   = (r_state == ST_DRAIN) && !w_busy && w_out_free;

    assign i_item.ready        = (r_state == ST_IDLE) && w_out_free;
    assign o_result.valid      = r_out_valid;
    assign o_result.best_index = r_out_idx;

    // ring: cell k holds entry k whenever idle, one full turn per search
    for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.load  = w_write_ok && (i_item.entry_index == 8'(k));
        assign w_ctl.shift = (r_state == ST_SCAN);
        npc_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_load_data (w_color),
            .i_next      (w_cell[(k + 1) % PALETTE_ENTRIES]),
            .o_data      (w_cell[k])
        );
    end

    assign w_dist_ctl.clear  = w_query && !w_hit;
    assign w_dist_ctl.sample = (r_state == ST_SCAN);

    npc_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_dist_ctl),
        .i_query    (r_query),
        .i_entry    (w_cell[0]),
        .i_idx      (r_cnt),
        .o_best_idx (w_best),
        .o_busy     (w_busy)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query && !w_hit) begin
                    n_state = ST_SCAN;
                    n_cnt   = '0;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_last_valid <= 1'b0;
            r_last_color <= '0;
            r_last_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_write_ok) begin
                r_last_valid <= 1'b0;
            end else if (w_finish) begin
                r_last_valid <= 1'b1;
                r_last_color <= r_query;
                r_last_idx   <= w_best;
            end
            if ((w_query && w_hit) || w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query && !w_hit) begin
            r_query <= w_color;
        end
        if (w_query && w_hit) begin
            r_out_idx <= 8'(r_last_idx);
        end else if (w_finish) begin
            r_out_idx <= 8'(w_best);
        end
    end

    a_write_clears_memory: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write_ok |=> !r_last_valid)
        else $error("palette write did not clear the query memory");

    a_hit_answers_at_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_query && w_hit) |=> (r_out_valid && (r_out_idx == 8'($past(r_last_idx)))))
        else $error("repeated query not answered from the query memory");

    a_finish_fills_memory: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_last_valid && r_out_valid && (r_state == ST_IDLE)))
        else $error("search end did not record its answer");

    a_scan_ends_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && (r_cnt == LAST_IDX)) |=> ((r_state == ST_DRAIN) && w_busy))
        else $error("ring turn did not end with the last entry in the distance unit");

endmodule

// ----- test/nearest_color_checker.sv -----
// Checker: predicts the nearest palette index of each query and compares the result stream.
`timescale 1ns / 1ps
module nearest_color_checker
    import npc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_mode,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_best_index,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int REPORT_LIMIT = 10;

    t_color           palette_colors [PALETTE_ENTRIES];
    t_color           recall_color;
    logic             recall_valid;
    logic [IDX_W-1:0] recall_index;
    logic [7:0]       expected_indices [$];
    int               fail_count;

    function automatic logic [DIST_W-1:0] color_distance(t_color a, t_color b);
        int dr;
        int dg;
        int db;
        dr = int'(a.red) - int'(b.red);
        dg = int'(a.green) - int'(b.green);
        db = int'(a.blue) - int'(b.blue);
        return DIST_W'(dr * dr + dg * dg + db * db);
    endfunction

    // Full palette scan; strict less-than keeps the lowest index on a tie.
    function automatic logic [IDX_W-1:0] closest_entry(t_color c);
        logic [DIST_W-1:0] best_dist;
        logic [DIST_W-1:0] entry_dist;
        logic [IDX_W-1:0]  best;
        best_dist = DIST_START;
        best      = '0;
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            entry_dist = color_distance(palette_colors[i], c);
            if (entry_dist < best_dist) begin
                best_dist = entry_dist;
                best      = IDX_W'(i);
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin
        t_color     query;
        logic [7:0] want;
        if (!i_rst_n) begin
            recall_color = '0;
            recall_valid = 1'b0;
            recall_index = '0;
            fail_count   = 0;
            expected_indices.delete();
        end else begin
            // results first: a result can never stem from the item accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_indices.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected result item, best_index %0d",
                                 $realtime, i_best_index);
                    fail_count++;
                end else begin
                    want = expected_indices.pop_front();
                    if (i_best_index !== want) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: best_index mismatch, expected %0d, got %0d",
                                     $realtime, want, i_best_index);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                query = '{red: i_red, green: i_green, blue: i_blue};
                if (i_mode == MODE_WRITE) begin
                    if (int'(i_entry_index) < PALETTE_ENTRIES) begin
                        palette_colors[i_entry_index] = query;
                        recall_valid = 1'b0;
                    end
                end else begin
                    if (!(recall_valid && recall_color == query)) begin
                        recall_index = closest_entry(query);
                        recall_color = query;
                        recall_valid = 1'b1;
                    end
                    expected_indices.push_back(8'(recall_index));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_indices.size();
    end

endmodule

// ----- test/tb_nearest_palette_color.sv -----
// Testbench top: drives palette loads and color queries with random idling and gives the verdict.
`timescale 1ns / 1ps
module tb_nearest_palette_color
    import npc_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_CYCLES = PALETTE_ENTRIES + 16;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    int     fail_count;
    int     pending;
    int     cycle_count = 0;
    bit     steady = 1'b0;
    t_color palette_shadow [PALETTE_ENTRIES];
    t_color last_query = '0;

    npc_in_if  item_ch ();
    npc_out_if result_ch ();

    nearest_palette_color u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    nearest_color_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (item_ch.valid),
        .i_in_ready    (item_ch.ready),
        .i_mode        (item_ch.mode),
        .i_entry_index (item_ch.entry_index),
        .i_red         (item_ch.red),
        .i_green       (item_ch.green),
        .i_blue        (item_ch.blue),
        .i_out_valid   (result_ch.valid),
        .i_out_ready   (result_ch.ready),
        .i_best_index  (result_ch.best_index),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_color rgb(int r, int g, int b);
        return '{red: 8'(r), green: 8'(g), blue: 8'(b)};
    endfunction

    function automatic t_color random_color();
        return t_color'(24'($urandom));
    endfunction

    // small offset around a color, clamped to the component range
    function automatic t_color nudge(t_color c);
        int r;
        int g;
        int b;
        r = int'(c.red) + $urandom_range(0, 6) - 3;
        g = int'(c.green) + $urandom_range(0, 6) - 3;
        b = int'(c.blue) + $urandom_range(0, 6) - 3;
        r = (r < 0) ? 0 : (r > 255) ? 255 : r;
        g = (g < 0) ? 0 : (g > 255) ? 255 : g;
        b = (b < 0) ? 0 : (b > 255) ? 255 : b;
        return rgb(r, g, b);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is accepted,
    // with valid still high so a back-to-back item never toggles it within one step.
    task automatic send_item(logic mode, logic [7:0] idx, t_color c);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= mode;
        item_ch.entry_index <= idx;
        item_ch.red         <= c.red;
        item_ch.green       <= c.green;
        item_ch.blue        <= c.blue;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (mode == MODE_WRITE) begin
            if (int'(idx) < PALETTE_ENTRIES) palette_shadow[idx] = c;
        end else begin
            last_query = c;
        end
        @(negedge i_clk);
    endtask

    // result side: random stall before each result item
    initial begin
        int stall;
        result_ch.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        t_color c;
        int     pick;
        item_ch.valid       = 1'b0;
        item_ch.mode        = MODE_WRITE;
        item_ch.entry_index = '0;
        item_ch.red         = '0;
        item_ch.green       = '0;
        item_ch.blue        = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full palette load before any query; some entries copy earlier ones for ties
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            c = random_color();
            if (i > 16 && i % 16 == 9) c = palette_shadow[$urandom_range(0, i - 1)];
            send_item(MODE_WRITE, 8'(i), c);
        end

        // directed: duplicated extremes, equidistant pairs, repeats and memory clearing
        send_item(MODE_WRITE, 8'd3, rgb(10, 10, 10));
        send_item(MODE_WRITE, 8'd4, rgb(12, 10, 10));
        send_item(MODE_WRITE, 8'd17, rgb(0, 0, 0));
        send_item(MODE_WRITE, 8'd200, rgb(0, 0, 0));
        send_item(MODE_WRITE, 8'd254, rgb(255, 255, 255));
        send_item(MODE_WRITE, 8'd255, rgb(255, 255, 255));
        send_item(MODE_QUERY, 8'd0, rgb(0, 0, 0));
        send_item(MODE_QUERY, 8'd255, rgb(255, 255, 255));
        send_item(MODE_QUERY, 8'd255, rgb(255, 255, 255));
        send_item(MODE_QUERY, 8'd0, rgb(255, 0, 0));
        send_item(MODE_QUERY, 8'd0, rgb(0, 255, 0));
        send_item(MODE_QUERY, 8'd0, rgb(0, 0, 255));
        send_item(MODE_QUERY, 8'd128, rgb(128, 128, 128));
        send_item(MODE_QUERY, 8'd0, rgb(11, 10, 10));
        send_item(MODE_QUERY, 8'd100, palette_shadow[100]);
        send_item(MODE_QUERY, 8'd0, rgb(1, 1, 1));
        send_item(MODE_WRITE, 8'd5, rgb(11, 10, 10));
        send_item(MODE_QUERY, 8'd0, rgb(11, 10, 10));
        send_item(MODE_WRITE, 8'd6, rgb(0, 0, 1));
        send_item(MODE_QUERY, 8'd0, rgb(11, 10, 10));
        send_item(MODE_QUERY, 8'd0, rgb(255, 255, 0));
        send_item(MODE_QUERY, 8'd0, rgb(0, 255, 255));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 60 && n < 100);
            if (n == 150) begin
                // hold off until every outstanding query has been answered
                item_ch.valid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                if ($urandom_range(0, 3) == 0)
                    c = palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)];
                else
                    c = random_color();
                send_item(MODE_WRITE, 8'($urandom), c);
            end else if (pick < 45) begin
                send_item(MODE_QUERY, 8'($urandom), last_query);
            end else if (pick < 70) begin
                c = nudge(palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)]);
                send_item(MODE_QUERY, 8'($urandom), c);
            end else if (pick < 75) begin
                c = rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                        $urandom_range(0, 1) * 255);
                send_item(MODE_QUERY, 8'($urandom), c);
            end else begin
                send_item(MODE_QUERY, 8'($urandom), random_color());
            end
        end
        steady = 1'b0;

        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/npc_pkg.sv
hdl/npc_ifs.sv
hdl/npc_cell.sv
hdl/npc_dist.sv
hdl/nearest_palette_color.sv
test/nearest_color_checker.sv
test/tb_nearest_palette_color.sv
